[rtl/core/qcrpm_pkg.sv]
// ============================================================================
// qcrpm_pkg - shared types and constants of the quadrature counter
// Widths, command codes, controller states and the result record used by
// the controller, the datapath and the result queue.
// ============================================================================
package qcrpm_pkg;

  // Width of the position counter and of the millisecond clock.
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned TIME_BITS  = 32;

  // Fixed field widths.
  localparam int unsigned CPR_W   = 16;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned Q_W     = 16;
  localparam int unsigned POS_W   = 32;

  // Derived datapath widths.
  localparam int unsigned NUM_W  = COUNT_BITS + SCALE_W;
  localparam int unsigned DEN_W  = TIME_BITS + CPR_W;
  localparam int unsigned DSH_W  = DEN_W + Q_W - 1;
  localparam int unsigned STEP_W = $clog2(Q_W);

  // Milliseconds per minute.
  localparam int unsigned RPM_SCALE = 1000 * 60;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [TIME_BITS-1:0]  tstamp_t;
  typedef logic [CPR_W-1:0]      cpr_t;
  typedef logic [NUM_W-1:0]      num_t;
  typedef logic [DEN_W-1:0]      den_t;
  typedef logic [DSH_W-1:0]      dsh_t;
  typedef logic [Q_W-1:0]        quo_t;
  typedef logic [STEP_W-1:0]     step_t;
  typedef logic signed [15:0]    speed_t;

  // Saturation limits of the 16-bit speed.
  localparam quo_t   POS_LIMIT = quo_t'(16'h7FFF);
  localparam quo_t   NEG_LIMIT = quo_t'(16'h8000);
  localparam speed_t SPEED_MAX = 16'sh7FFF;
  localparam speed_t SPEED_MIN = -16'sh8000;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_SPEED  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_INIT,
    ST_DIV,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic load_mul;
    logic div_init;
    logic div_step;
    logic finish;
  } ctrl_t;

  // One result item.
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    speed_t                  speed_rpm;
    logic                    speed_fresh;
    logic                    fault;
  } result_t;

endpackage

[rtl/core/qcrpm_in_if.sv]
// ============================================================================
// qcrpm_in_if - sample channel of the quadrature counter
// Valid/ready channel carrying the command and the two pin levels.
// ============================================================================
interface qcrpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       pin_a;
  logic       pin_b;

  modport source (output valid, output command, output pin_a, output pin_b, input ready);
  modport sink   (input valid, input command, input pin_a, input pin_b, output ready);
endinterface

[rtl/core/qcrpm_out_if.sv]
// ============================================================================
// qcrpm_out_if - result channel of the quadrature counter
// Valid/ready channel carrying position, speed and status flags.
// ============================================================================
interface qcrpm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [15:0] speed_rpm;
  logic               speed_fresh;
  logic               fault;

  modport source (output valid, output position, output speed_rpm, output speed_fresh,
                  output fault, input ready);
  modport sink   (input valid, input position, input speed_rpm, input speed_fresh,
                  input fault, output ready);
endinterface

[rtl/core/quadrature_counter_with_rpm_top.sv]
// ============================================================================
// quadrature_counter_with_rpm_top - x4 quadrature decoder with speed output
// Counts every edge of an A/B encoder and turns the count change over a
// millisecond window into revolutions per minute.
// ============================================================================
// Each item on the sample channel gives exactly one result item. A pin
// sample, a millisecond tick or a clear is pushed to the queue in the cycle
// it is taken and, when the result channel keeps up, a new one can follow
// in every clock. A speed update runs through these steps from acceptance
// to its result: forming the count and time deltas, the two multiplications
// (delta count by 60000, delta time by counts per revolution), setting up
// the divider, the restoring divider that resolves one quotient bit per
// clock, and applying sign and saturation; no sample is taken meanwhile.
// The result is truncated toward zero and saturated to the signed 16-bit
// range; a zero time window yields speed 0 with fault set. Finished results
// wait in a two-entry queue, so items keep being taken while the sink
// stalls until that queue is full. The counts-per-revolution register
// resets to 1 and a write of zero is ignored.
module quadrature_counter_with_rpm_top (
  input  logic                 clk,
  input  logic                 rst,
  qcrpm_in_if.sink             sample_ch,
  qcrpm_out_if.source          result_ch,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);

  qcrpm_pkg::ctrl_t   ctrl_cmd;
  qcrpm_pkg::result_t dp_result;
  qcrpm_pkg::result_t head;
  logic               is_speed;
  logic               queue_full;
  logic               queue_not_empty;
  logic               push;
  logic               pop;

  // The controller only needs to know whether the offered item is a speed
  // update, since that is the one command that runs the divider.
  assign is_speed = (qcrpm_pkg::cmd_t'(sample_ch.command) == qcrpm_pkg::CMD_SPEED);
  assign pop      = queue_not_empty && result_ch.ready;

  qcrpm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (sample_ch.valid),
    .is_speed   (is_speed),
    .queue_full (queue_full),
    .in_ready   (sample_ch.ready),
    .push       (push),
    .cmd        (ctrl_cmd)
  );

  qcrpm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctrl_cmd),
    .command   (sample_ch.command),
    .pin_a     (sample_ch.pin_a),
    .pin_b     (sample_ch.pin_b),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (dp_result)
  );

  qcrpm_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (dp_result),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head)
  );

  // The result channel is driven straight from the head of the queue.
  assign result_ch.valid       = queue_not_empty;
  assign result_ch.position    = head.position;
  assign result_ch.speed_rpm   = head.speed_rpm;
  assign result_ch.speed_fresh = head.speed_fresh;
  assign result_ch.fault       = head.fault;

`ifndef SYNTHESIS
  // A result must never be written into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full)
    else $error("result pushed into full queue");

  // The multiply stage is always followed by the divider set-up.
  a_mul_then_init: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.load_mul |=> ctrl_cmd.div_init)
    else $error("divider set-up did not follow multiply");

  // A fresh speed is only ever produced by the end of a division.
  a_fresh_from_div: assert property (@(posedge clk) disable iff (rst)
    (push && dp_result.speed_fresh) |-> ctrl_cmd.finish)
    else $error("fresh speed pushed outside division finish");

  // No item is taken while a division is running.
  a_no_take_in_div: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.div_step |-> !sample_ch.ready)
    else $error("item accepted during division");
`endif

endmodule

[rtl/core/qcrpm_ctrl.sv]
// ============================================================================
// qcrpm_ctrl - controller of the quadrature counter
// Accepts items, and sequences multiply, divider set-up, the restoring
// division steps and the final saturation of a speed update.
// ============================================================================
module qcrpm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              is_speed,
  input  logic              queue_full,
  output logic              in_ready,
  output logic              push,
  output qcrpm_pkg::ctrl_t  cmd
);

  qcrpm_pkg::state_t state, state_next;
  qcrpm_pkg::step_t  step_cnt, step_cnt_next;
  logic              take;

  assign in_ready = (state == qcrpm_pkg::ST_IDLE) && !queue_full;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= qcrpm_pkg::ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  // Next state.
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    case (state)
      qcrpm_pkg::ST_IDLE: begin
        if (take && is_speed) begin
          state_next = qcrpm_pkg::ST_MUL;
        end
      end
      qcrpm_pkg::ST_MUL: begin
        state_next = qcrpm_pkg::ST_INIT;
      end
      qcrpm_pkg::ST_INIT: begin
        state_next    = qcrpm_pkg::ST_DIV;
        step_cnt_next = qcrpm_pkg::step_t'(qcrpm_pkg::Q_W - 1);
      end
      qcrpm_pkg::ST_DIV: begin
        if (step_cnt == '0) begin
          state_next = qcrpm_pkg::ST_FIN;
        end else begin
          step_cnt_next = step_cnt - qcrpm_pkg::step_t'(1);
        end
      end
      qcrpm_pkg::ST_FIN: begin
        state_next = qcrpm_pkg::ST_IDLE;
      end
      default: begin
        state_next = qcrpm_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    cmd.take = take;
    push     = 1'b0;
    case (state)
      qcrpm_pkg::ST_IDLE: push         = take && !is_speed;
      qcrpm_pkg::ST_MUL:  cmd.load_mul = 1'b1;
      qcrpm_pkg::ST_INIT: cmd.div_init = 1'b1;
      qcrpm_pkg::ST_DIV:  cmd.div_step = 1'b1;
      qcrpm_pkg::ST_FIN: begin
        cmd.finish = 1'b1;
        push       = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/qcrpm_dp.sv]
// ============================================================================
// qcrpm_dp - datapath of the quadrature counter
// Position and clock state, speed window, two multipliers and a restoring
// divider that produces one quotient bit per step.
// ============================================================================
module qcrpm_dp (
  input  logic                clk,
  input  logic                rst,
  input  qcrpm_pkg::ctrl_t    cmd,
  input  logic [1:0]          command,
  input  logic                pin_a,
  input  logic                pin_b,
  input  logic                cfg_we,
  input  qcrpm_pkg::cpr_t     cfg_wdata,
  output qcrpm_pkg::result_t  result
);

  // Architectural state.
  qcrpm_pkg::count_t  position_count;
  logic               prev_a;
  logic               prev_b;
  qcrpm_pkg::tstamp_t ms_clock;
  qcrpm_pkg::tstamp_t last_update_ms;
  qcrpm_pkg::count_t  last_update_count;
  qcrpm_pkg::speed_t  last_speed;
  qcrpm_pkg::cpr_t    counts_per_rev;

  // Speed working registers.
  qcrpm_pkg::tstamp_t dms;
  qcrpm_pkg::count_t  mag;
  logic               neg;
  logic               zero_dt;
  qcrpm_pkg::num_t    num;
  qcrpm_pkg::den_t    den;
  qcrpm_pkg::num_t    rem;
  qcrpm_pkg::dsh_t    dsh;
  qcrpm_pkg::quo_t    quo;

  qcrpm_pkg::cmd_t    code;
  logic               ca;
  logic               cb;
  logic               item_fault;
  qcrpm_pkg::count_t  position_count_next;
  qcrpm_pkg::count_t  dcount;
  qcrpm_pkg::tstamp_t dms_next;
  qcrpm_pkg::speed_t  speed_new;
  qcrpm_pkg::count_t  pos_src;

  always_comb begin
    code                = qcrpm_pkg::cmd_t'(command);
    ca                  = pin_a != prev_a;
    cb                  = pin_b != prev_b;
    item_fault          = 1'b0;
    position_count_next = position_count;
    case (code)
      qcrpm_pkg::CMD_SAMPLE: begin
        if (ca && cb) begin
          item_fault = 1'b1;
        end else if (ca) begin
          position_count_next = (pin_a != pin_b) ?
                                position_count + qcrpm_pkg::count_t'(1) :
                                position_count - qcrpm_pkg::count_t'(1);
        end else if (cb) begin
          position_count_next = (pin_a == pin_b) ?
                                position_count + qcrpm_pkg::count_t'(1) :
                                position_count - qcrpm_pkg::count_t'(1);
        end
      end
      qcrpm_pkg::CMD_CLEAR: position_count_next = '0;
      default: ;
    endcase
  end

  assign dcount   = position_count - last_update_count;
  assign dms_next = ms_clock - last_update_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count    <= '0;
      prev_a            <= 1'b0;
      prev_b            <= 1'b0;
      ms_clock          <= '0;
      last_update_ms    <= '0;
      last_update_count <= '0;
      last_speed        <= '0;
      counts_per_rev    <= qcrpm_pkg::cpr_t'(1);
    end else begin
      if (cfg_we && cfg_wdata != '0) begin
        counts_per_rev <= cfg_wdata;
      end
      if (cmd.take) begin
        position_count <= position_count_next;
        if (code == qcrpm_pkg::CMD_SAMPLE) begin
          prev_a <= pin_a;
          prev_b <= pin_b;
        end
        if (code == qcrpm_pkg::CMD_TICK) begin
          ms_clock <= ms_clock + qcrpm_pkg::tstamp_t'(1);
        end
        if (code == qcrpm_pkg::CMD_SPEED) begin
          last_update_ms    <= ms_clock;
          last_update_count <= position_count;
        end
      end
      if (cmd.finish) begin
        last_speed <= speed_new;
      end
    end
  end

  // Speed pipeline: window deltas, products, then the division steps.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      dms     <= dms_next;
      neg     <= dcount[qcrpm_pkg::COUNT_BITS-1];
      mag     <= dcount[qcrpm_pkg::COUNT_BITS-1] ? (~dcount + qcrpm_pkg::count_t'(1)) : dcount;
      zero_dt <= (dms_next == '0);
    end
    if (cmd.load_mul) begin
      num <= qcrpm_pkg::num_t'(mag) * qcrpm_pkg::num_t'(qcrpm_pkg::RPM_SCALE);
      den <= qcrpm_pkg::den_t'(dms) * qcrpm_pkg::den_t'(counts_per_rev);
    end
    if (cmd.div_init) begin
      rem <= num;
      dsh <= qcrpm_pkg::dsh_t'(den) << (qcrpm_pkg::Q_W - 1);
      quo <= '0;
    end else if (cmd.div_step) begin
      if (qcrpm_pkg::dsh_t'(rem) >= dsh) begin
        rem <= rem - qcrpm_pkg::num_t'(dsh);
        quo <= {quo[qcrpm_pkg::Q_W-2:0], 1'b1};
      end else begin
        quo <= {quo[qcrpm_pkg::Q_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  // Sign and saturation of the quotient.
  always_comb begin
    if (zero_dt) begin
      speed_new = '0;
    end else if (neg) begin
      speed_new = (quo > qcrpm_pkg::NEG_LIMIT) ? qcrpm_pkg::SPEED_MIN :
                  qcrpm_pkg::speed_t'(~quo + qcrpm_pkg::quo_t'(1));
    end else begin
      speed_new = (quo > qcrpm_pkg::POS_LIMIT) ? qcrpm_pkg::SPEED_MAX :
                  qcrpm_pkg::speed_t'(quo);
    end
  end

  assign pos_src = cmd.finish ? position_count : position_count_next;

  always_comb begin
    result.position = qcrpm_pkg::POS_W'($signed(pos_src));
    if (cmd.finish) begin
      result.speed_rpm   = speed_new;
      result.speed_fresh = 1'b1;
      result.fault       = zero_dt;
    end else begin
      result.speed_rpm   = last_speed;
      result.speed_fresh = 1'b0;
      result.fault       = item_fault;
    end
  end

endmodule

[rtl/core/qcrpm_outq.sv]
// ============================================================================
// qcrpm_outq - two-entry result queue
// Holds finished results so that new items can be taken while the sink
// stalls.
// ============================================================================
module qcrpm_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  qcrpm_pkg::result_t  push_data,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output qcrpm_pkg::result_t  head
);

  qcrpm_pkg::result_t slot [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the quadrature counter with speed
// Drives pin samples, millisecond ticks, speed updates and clears with
// bursty timing, stalls the result side and checks every result item
// against a cycle-free predictor of the decoder.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qcrpm_pkg::*;

  // Quiet cycles allowed before the run is declared hung. A speed update
  // and a stall on the result side are both much shorter, so this is
  // many times the longest legitimate pause.
  localparam int WATCHDOG_LIMIT  = 2000;
  // Cycles allowed after the last result for anything unexpected to show.
  localparam int SETTLE_CYCLES   = 40;
  // Spare cycles before a register write once every result is in.
  localparam int DRAIN_CYCLES    = 4;
  localparam int ITEMS_PER_PHASE = 312;
  localparam int MAX_REPORTS     = 100;
  localparam int PHASES          = 6;
  // Milliseconds per minute, used to turn counts per millisecond into rpm.
  localparam longint unsigned MS_PER_MIN = 60000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  qcrpm_in_if  sample_ch ();
  qcrpm_out_if result_ch ();

  quadrature_counter_with_rpm_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: our own copy of the decoder, the millisecond clock, the
  // speed measuring window and the counts-per-revolution register.
  // --------------------------------------------------------------------------
  count_t  enc_position = '0;
  logic    enc_prev_a   = 1'b0;
  logic    enc_prev_b   = 1'b0;
  tstamp_t ms_ticks     = '0;
  tstamp_t window_ms    = '0;
  count_t  window_count = '0;
  speed_t  held_speed   = '0;
  cpr_t    rev_counts   = cpr_t'(1);

  // Results predicted for accepted items, oldest first.
  result_t pending_results[$];

  int mismatch_count = 0;
  int burst_left     = 0;
  int quiet_cycles   = 0;

  // Speed over a window: the count change is signed, the magnitude is scaled
  // to counts per minute, divided by counts per revolution times elapsed
  // milliseconds, truncated toward zero and clamped to the signed 16-bit
  // range. The minimum is reachable one step further than the maximum.
  function automatic speed_t speed_over_window(count_t dcount, tstamp_t dms, cpr_t cpr);
    count_t          mag;
    longint unsigned num;
    longint unsigned den;
    longint unsigned quo;
    mag = dcount[COUNT_BITS-1] ? -dcount : dcount;
    num = longint'(mag) * MS_PER_MIN;
    den = longint'(dms) * longint'(cpr);
    quo = num / den;
    if (dcount[COUNT_BITS-1]) begin
      if (quo > 32768) return SPEED_MIN;
      return -speed_t'(quo[15:0]);
    end
    if (quo > 32767) return SPEED_MAX;
    return speed_t'(quo[15:0]);
  endfunction

  // Advances the predictor by one item and returns the result it should give.
  function automatic result_t decode_item(cmd_t cmd, logic a, logic b);
    result_t r;
    tstamp_t dms;
    count_t  dcount;
    logic    fresh;
    logic    fault;
    fresh = 1'b0;
    fault = 1'b0;
    case (cmd)
      CMD_SAMPLE: begin
        // An edge on both channels at once cannot be decoded: hold the count.
        if (a != enc_prev_a && b != enc_prev_b) begin
          fault = 1'b1;
        end else if (a != enc_prev_a) begin
          enc_position = (a != b) ? enc_position + 1'b1 : enc_position - 1'b1;
        end else if (b != enc_prev_b) begin
          enc_position = (a == b) ? enc_position + 1'b1 : enc_position - 1'b1;
        end
        enc_prev_a = a;
        enc_prev_b = b;
      end
      CMD_TICK: begin
        ms_ticks = ms_ticks + 1'b1;
      end
      CMD_SPEED: begin
        dms    = ms_ticks - window_ms;
        dcount = enc_position - window_count;
        fresh  = 1'b1;
        if (dms == '0) begin
          held_speed = '0;
          fault      = 1'b1;
        end else begin
          held_speed = speed_over_window(dcount, dms, rev_counts);
        end
        window_ms    = ms_ticks;
        window_count = enc_position;
      end
      default: begin
        // A clear only zeroes the count; the speed window is left alone.
        enc_position = '0;
      end
    endcase
    r.position    = enc_position;
    r.speed_rpm   = held_speed;
    r.speed_fresh = fresh;
    r.fault       = fault;
    return r;
  endfunction

  // Prints one line per mismatch, up to a cap so a broken build stays readable.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Directed items. Where the result is obvious (straight after reset, a
  // double edge, a zero time window, saturation) it is written out here;
  // rows with typed = 0 are checked against the predictor.
  // --------------------------------------------------------------------------
  typedef struct {
    cmd_t    cmd;
    logic    a;
    logic    b;
    bit      typed;
    result_t want;
  } stim_row_t;

  stim_row_t directed_rows [25] = '{
    // First sample after reset sees levels 0 and 0: no edge.
    '{CMD_SAMPLE, 1'b0, 1'b0, 1'b1, '{32'sd0, 16'sd0, 1'b0, 1'b0}},
    // Both channels change together: count holds and fault is raised.
    '{CMD_SAMPLE, 1'b1, 1'b1, 1'b1, '{32'sd0, 16'sd0, 1'b0, 1'b1}},
    // Speed update with no millisecond elapsed.
    '{CMD_SPEED,  1'b0, 1'b1, 1'b1, '{32'sd0, 16'sd0, 1'b1, 1'b1}},
    // One full forward cycle, each edge on A and on B in turn, then two steps back.
    '{CMD_SAMPLE, 1'b0, 1'b1, 1'b0, '0},
    '{CMD_SAMPLE, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_SAMPLE, 1'b1, 1'b0, 1'b0, '0},
    '{CMD_SAMPLE, 1'b1, 1'b1, 1'b0, '0},
    '{CMD_SAMPLE, 1'b1, 1'b0, 1'b0, '0},
    '{CMD_SAMPLE, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_SAMPLE, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_TICK,   1'b1, 1'b1, 1'b0, '0},
    '{CMD_TICK,   1'b0, 1'b0, 1'b0, '0},
    // Two counts in two milliseconds at one count per revolution: clamps high.
    '{CMD_SPEED,  1'b1, 1'b0, 1'b1, '{32'sd2, SPEED_MAX, 1'b1, 1'b0}},
    '{CMD_CLEAR,  1'b1, 1'b1, 1'b1, '{32'sd0, SPEED_MAX, 1'b0, 1'b0}},
    '{CMD_SPEED,  1'b0, 1'b0, 1'b1, '{32'sd0, 16'sd0, 1'b1, 1'b1}},
    '{CMD_TICK,   1'b0, 1'b0, 1'b0, '0},
    '{CMD_SAMPLE, 1'b0, 1'b1, 1'b0, '0},
    '{CMD_SAMPLE, 1'b1, 1'b1, 1'b0, '0},
    // Two counts backwards in one millisecond: clamps low.
    '{CMD_SPEED,  1'b0, 1'b0, 1'b1, '{-32'sd2, SPEED_MIN, 1'b1, 1'b0}},
    '{CMD_TICK,   1'b1, 1'b0, 1'b0, '0},
    '{CMD_TICK,   1'b0, 1'b1, 1'b0, '0},
    '{CMD_TICK,   1'b1, 1'b1, 1'b0, '0},
    '{CMD_SAMPLE, 1'b0, 1'b1, 1'b0, '0},
    '{CMD_SPEED,  1'b1, 1'b1, 1'b0, '0},
    '{CMD_CLEAR,  1'b0, 1'b1, 1'b0, '0}
  };

  // Presents one item and holds it until the block takes it, then records
  // what the block should answer. Returns in the step of acceptance without
  // touching valid, so the caller may keep it high for the next item.
  task automatic drive_item(input cmd_t cmd, input logic a, input logic b,
                            input bit typed, input result_t want);
    result_t predicted;
    sample_ch.valid   <= 1'b1;
    sample_ch.command <= cmd;
    sample_ch.pin_a   <= a;
    sample_ch.pin_b   <= b;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predicted = decode_item(cmd, a, b);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Sends items in bursts: mostly short ones with idle gaps between them,
  // now and then a long stretch with no idling at all.
  task automatic send_item(input cmd_t cmd, input logic a, input logic b,
                           input bit typed, input result_t want);
    if (burst_left == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    drive_item(cmd, a, b, typed, want);
  endtask

  // Writes counts per revolution once the block has nothing in flight.
  // A write of zero leaves the register as it was.
  task automatic write_rev_counts(input cpr_t value);
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (value != '0) rev_counts = value;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: reset, the directed table, then random phases, each under its
  // own counts-per-revolution setting.
  // --------------------------------------------------------------------------
  initial begin
    cpr_t cpr_plan [PHASES];
    int   pick;
    int   style;
    cmd_t cmd;
    logic a;
    logic b;
    bit   moving_up;

    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    sample_ch.valid   <= 1'b0;
    sample_ch.command <= CMD_SAMPLE;
    sample_ch.pin_a   <= 1'b0;
    sample_ch.pin_b   <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The directed part runs on the reset value of the register.
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b,
                directed_rows[i].typed, directed_rows[i].want);
    end

    // Both extremes, an ignored zero write, and a few spread settings. Small
    // divisors give the widest spread of speeds, including both clamps.
    cpr_plan[0] = cpr_t'(1);
    cpr_plan[1] = cpr_t'(16'hFFFF);
    cpr_plan[2] = cpr_t'(0);
    cpr_plan[3] = cpr_t'($urandom_range(2, 60));
    cpr_plan[4] = cpr_t'($urandom_range(1, 65535));
    cpr_plan[5] = cpr_t'($urandom_range(1, 8));
    moving_up   = 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      write_rev_counts(cpr_plan[phase]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        // Pins carry random levels on commands that ignore them.
        a = 1'($urandom_range(0, 1));
        b = 1'($urandom_range(0, 1));
        if (pick < 64) begin
          cmd   = CMD_SAMPLE;
          style = $urandom_range(0, 19);
          if ($urandom_range(0, 19) == 0) moving_up = !moving_up;
          if (style < 16) begin
            // A clean quadrature step: the forward order of {A,B} is
            // 00, 10, 11, 01 and the reverse order steps back through it.
            case ({enc_prev_a, enc_prev_b})
              2'b00:   {a, b} = moving_up ? 2'b10 : 2'b01;
              2'b10:   {a, b} = moving_up ? 2'b11 : 2'b00;
              2'b11:   {a, b} = moving_up ? 2'b01 : 2'b10;
              default: {a, b} = moving_up ? 2'b00 : 2'b11;
            endcase
          end else if (style == 16) begin
            {a, b} = {enc_prev_a, enc_prev_b};
          end
          // Otherwise the random levels stand: noise, double edges included.
        end else if (pick < 86) begin
          cmd = CMD_TICK;
        end else if (pick < 97) begin
          cmd = CMD_SPEED;
        end else begin
          cmd = CMD_CLEAR;
        end
        send_item(cmd, a, b, 1'b0, '0);
      end
    end

    sample_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side back-pressure: runs of steady acceptance, random stalls,
  // mostly-stalled stretches and single long stalls, chosen at random.
  // --------------------------------------------------------------------------
  initial begin
    int mode;
    int span;
    result_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = (mode == 3) ? $urandom_range(1, 30) : $urandom_range(20, 150);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= 1'($urandom_range(0, 1));
          2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
          default: result_ch.ready <= 1'b0;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking: each accepted result item is compared field by field
  // with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result item with nothing expected, position %0d",
                                  result_ch.position));
      end else begin
        want = pending_results.pop_front();
        if (result_ch.position !== want.position)
          report_mismatch($sformatf("position got %0d want %0d",
                                    result_ch.position, want.position));
        if (result_ch.speed_rpm !== want.speed_rpm)
          report_mismatch($sformatf("speed_rpm got %0d want %0d",
                                    result_ch.speed_rpm, want.speed_rpm));
        if (result_ch.speed_fresh !== want.speed_fresh)
          report_mismatch($sformatf("speed_fresh got %b want %b",
                                    result_ch.speed_fresh, want.speed_fresh));
        if (result_ch.fault !== want.fault)
          report_mismatch($sformatf("fault got %b want %b",
                                    result_ch.fault, want.fault));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any cycle in which no item moves on either channel counts
  // towards the limit; any movement starts the count again.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

endmodule
